@@ hw/rtl/fixed_point_radix2_fft_assert.svh @@
// Assertion macros for the FFT block
`ifndef FIXED_POINT_RADIX2_FFT_ASSERT_SVH
`define FIXED_POINT_RADIX2_FFT_ASSERT_SVH
`ifndef SYNTHESIS
`define FFT_ASSERT_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define FFT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define FFT_ASSERT_IMPL(label, clk, rst, cond, msg)
`define FFT_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

@@ hw/rtl/fft_pkg.sv @@
`timescale 1ns / 1ps
package fft_pkg;
   localparam int MAX_LOG2 = 6;
   localparam int MAX_N = 1 << MAX_LOG2;
   localparam int AW = MAX_LOG2;
   localparam int ROM_LOG2 = 8;

   localparam logic [0:0] CSR_SIZE_LOG2 = 1'b0;
   localparam logic [0:0] CSR_INVERSE = 1'b1;

   typedef logic signed [15:0] sample_type;

   typedef struct packed {
      logic             valid;
      logic [AW-1:0]    addr_a;
      logic [AW-1:0]    addr_b;
      logic             twiddle_zero;
      logic             twiddle_quarter;
      logic [6:0]       rom_k;
      logic             shift;
   } bfly_cmd_type;

   function automatic logic signed [15:0] quarter_rom(input logic [6:0] k);
      logic signed [15:0] r;
      case (k)
         7'd0: r = 16'sd32767; 7'd1: r = 16'sd32757; 7'd2: r = 16'sd32727;
         7'd3: r = 16'sd32678; 7'd4: r = 16'sd32609; 7'd5: r = 16'sd32520;
         7'd6: r = 16'sd32412; 7'd7: r = 16'sd32284; 7'd8: r = 16'sd32137;
         7'd9: r = 16'sd31970; 7'd10: r = 16'sd31785; 7'd11: r = 16'sd31580;
         7'd12: r = 16'sd31356; 7'd13: r = 16'sd31113; 7'd14: r = 16'sd30851;
         7'd15: r = 16'sd30571; 7'd16: r = 16'sd30272; 7'd17: r = 16'sd29955;
         7'd18: r = 16'sd29621; 7'd19: r = 16'sd29268; 7'd20: r = 16'sd28897;
         7'd21: r = 16'sd28510; 7'd22: r = 16'sd28105; 7'd23: r = 16'sd27683;
         7'd24: r = 16'sd27244; 7'd25: r = 16'sd26789; 7'd26: r = 16'sd26318;
         7'd27: r = 16'sd25831; 7'd28: r = 16'sd25329; 7'd29: r = 16'sd24811;
         7'd30: r = 16'sd24278; 7'd31: r = 16'sd23731; 7'd32: r = 16'sd23169;
         7'd33: r = 16'sd22594; 7'd34: r = 16'sd22004; 7'd35: r = 16'sd21402;
         7'd36: r = 16'sd20787; 7'd37: r = 16'sd20159; 7'd38: r = 16'sd19519;
         7'd39: r = 16'sd18867; 7'd40: r = 16'sd18204; 7'd41: r = 16'sd17530;
         7'd42: r = 16'sd16845; 7'd43: r = 16'sd16150; 7'd44: r = 16'sd15446;
         7'd45: r = 16'sd14732; 7'd46: r = 16'sd14009; 7'd47: r = 16'sd13278;
         7'd48: r = 16'sd12539; 7'd49: r = 16'sd11792; 7'd50: r = 16'sd11038;
         7'd51: r = 16'sd10278; 7'd52: r = 16'sd9511; 7'd53: r = 16'sd8739;
         7'd54: r = 16'sd7961; 7'd55: r = 16'sd7179; 7'd56: r = 16'sd6392;
         7'd57: r = 16'sd5601; 7'd58: r = 16'sd4807; 7'd59: r = 16'sd4011;
         7'd60: r = 16'sd3211; 7'd61: r = 16'sd2410; 7'd62: r = 16'sd1607;
         7'd63: r = 16'sd804;
         default: r = 16'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] rom_cos(input logic [6:0] k);
      logic signed [15:0] r;
      if (k <= 7'd64) r = quarter_rom(k);
      else r = -quarter_rom(7'(8'd128 - {1'b0, k}));
      return r;
   endfunction

   function automatic logic signed [15:0] rom_sin(input logic [6:0] k);
      logic signed [15:0] r;
      if (k <= 7'd64) r = quarter_rom(7'(7'd64 - k));
      else r = quarter_rom(7'(k - 7'd64));
      return r;
   endfunction
endpackage

@@ hw/rtl/fft_sequencer.sv @@
`timescale 1ns / 1ps
// Walks stages, groups and butterflies; one command per cycle outside the
// idle cycles between stages, which let the last writes of a stage land
// before the next stage reads them.
module fft_sequencer import fft_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [2:0]         m,
   output bfly_cmd_type       cmd,
   output logic               done
);
   logic [2:0]    stage_ff, stage_in;
   logic [AW-1:0] j_ff, j_in;
   logic [AW-1:0] i_ff, i_in;
   logic          run_ff, run_in;
   logic [1:0]    gap_ff, gap_in;
   logic [AW:0]   span;
   logic [AW:0]   n;
   logic [AW:0]   next_i;
   logic [3:0]    k_shift;
   logic [ROM_LOG2-1:0] k_full;

   always_comb begin
      span = (AW+1)'(1) << stage_ff;
      n = (AW+1)'(1) << m;
      next_i = {1'b0, i_ff} + (span << 1);
      k_shift = 4'(ROM_LOG2 - 1) - {1'b0, stage_ff};
      k_full = ROM_LOG2'({2'b0, j_ff} << k_shift);
      cmd.valid = run_ff && (gap_ff == 2'd0);
      cmd.addr_a = i_ff;
      cmd.addr_b = AW'({1'b0, i_ff} + span);
      cmd.twiddle_zero = (j_ff == '0);
      cmd.twiddle_quarter = ({1'b0, j_ff} == (span >> 1));
      cmd.rom_k = k_full[6:0];
      cmd.shift = stage_ff[0];
      run_in = run_ff;
      stage_in = stage_ff;
      j_in = j_ff;
      i_in = i_ff;
      gap_in = gap_ff;
      done = 1'b0;
      if (go) begin
         run_in = 1'b1;
         stage_in = '0;
         j_in = '0;
         i_in = '0;
         gap_in = '0;
      end else if (run_ff) begin
         if (gap_ff != 2'd0) begin
            gap_in = gap_ff - 2'd1;
         end else if (next_i < n) begin
            i_in = next_i[AW-1:0];
         end else if (({1'b0, j_ff} + 1'b1) < span) begin
            j_in = j_ff + 1'b1;
            i_in = j_ff + 1'b1;
         end else if ((stage_ff + 3'd1) < m) begin
            stage_in = stage_ff + 3'd1;
            j_in = '0;
            i_in = '0;
            gap_in = 2'd2;
         end else begin
            run_in = 1'b0;
            done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         stage_ff <= '0;
         j_ff <= '0;
         i_ff <= '0;
         gap_ff <= '0;
      end else begin
         run_ff <= run_in;
         stage_ff <= stage_in;
         j_ff <= j_in;
         i_ff <= i_in;
         gap_ff <= gap_in;
      end
   end
endmodule

@@ hw/rtl/fft_butterfly.sv @@
`timescale 1ns / 1ps
// Butterfly datapath: rotate, multiply register, add/sub and scale.
module fft_butterfly import fft_pkg::*; (
   input  logic         clock,
   input  bfly_cmd_type cmd,
   input  sample_type   ar, ai, br, bi,
   output bfly_cmd_type cmd_out,
   output sample_type   yr0, yi0, yr1, yi1
);
   bfly_cmd_type       cmd_ff;
   sample_type         ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [31:0] p0_ff, p1_ff, p2_ff, p3_ff;
   sample_type         c, s;
   sample_type         xr, xi;
   logic signed [16:0] pr, mr, pi, mi;

   always_comb begin
      c = rom_cos(cmd.rom_k);
      s = -rom_sin(cmd.rom_k);
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd;
      ar_ff <= ar;
      ai_ff <= ai;
      br_ff <= br;
      bi_ff <= bi;
      p0_ff <= br * c;
      p1_ff <= bi * s;
      p2_ff <= br * s;
      p3_ff <= bi * c;
   end

   always_comb begin
      if (cmd_ff.twiddle_zero) begin
         xr = br_ff;
         xi = bi_ff;
      end else if (cmd_ff.twiddle_quarter) begin
         xr = bi_ff;
         xi = -br_ff;
      end else begin
         xr = p0_ff[30:15] - p1_ff[30:15];
         xi = p2_ff[30:15] + p3_ff[30:15];
      end
      mr = 17'(sample_type'(ar_ff - xr));
      mi = 17'(sample_type'(ai_ff - xi));
      pr = 17'(sample_type'(ar_ff + xr));
      pi = 17'(sample_type'(ai_ff + xi));
      if (cmd_ff.shift) begin
         mr = mr >>> 1; mi = mi >>> 1; pr = pr >>> 1; pi = pi >>> 1;
      end
      cmd_out = cmd_ff;
      yr0 = pr[15:0];
      yi0 = pi[15:0];
      yr1 = mr[15:0];
      yi1 = mi[15:0];
   end
endmodule

@@ hw/rtl/fixed_point_radix2_fft.sv @@
`timescale 1ns / 1ps
// Channel | ports                                       | dir | handshake
// request | req_sample_real, req_sample_imag           | in  | start & !busy
// result  | rsp_bin_real, rsp_bin_imag, rsp_bin_last    | out | rsp_valid, no stall
// config  | csr_index, csr_data                         | in  | csr_valid & csr_ready
//
// Load accepts one word per cycle while start is high. After the last word
// the block is busy: bit reversal walks the store, butterflies issue one per
// cycle outside the idle gaps between stages (read, multiply, write latency),
// then the pipeline drains and the bins unload; each bin leaves in the cycle
// after its read.
// The store is two dual-port memories (real and imaginary) with registered
// reads. Reset is synchronous; memories hold no reset. The receiver
// cannot stall.
module fixed_point_radix2_fft import fft_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_sample_real,
   input  logic signed [15:0] req_sample_imag,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_bin_real,
   output logic signed [15:0] rsp_bin_imag,
   output logic               rsp_bin_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [2:0]         csr_data
);
   typedef enum logic [2:0] {
      S_LOAD, S_REV, S_BFLY, S_DRAIN, S_OUT
   } state_type;

   state_type     state_ff, state_in;
   logic [2:0]    size_ff;
   logic          inv_ff;
   logic [AW:0]   cnt_ff, cnt_in;
   logic [2:0]    m_ff, m_in;
   logic          inv_blk_ff, inv_blk_in;
   logic [1:0]    drain_ff, drain_in;
   logic          go;
   logic          seq_done;
   logic [2:0]    m_eff;

   // two memories: re and im, each dual port
   sample_type    mem_re [MAX_N];
   sample_type    mem_im [MAX_N];
   logic [AW-1:0] rd_a, rd_b;
   sample_type    qa_re_ff, qa_im_ff, qb_re_ff, qb_im_ff;
   logic          we_a, we_b;
   logic [AW-1:0] wa, wb;
   sample_type    wa_re, wa_im, wb_re, wb_im;

   bfly_cmd_type  cmd, cmd_ff, cmd_wb;
   sample_type    yr0, yi0, yr1, yi1;
   sample_type    bf_ar, bf_ai, bf_br, bf_bi;

   // bit reverse copy and output pipeline
   logic          rev_v_ff;
   logic [AW-1:0] rev_i_ff, rev_ip_ff;
   logic          out_v_ff;
   logic [AW:0]   out_k_ff;

   always_comb begin
      m_eff = (size_ff == 3'd0) ? 3'd1 :
              (size_ff > 3'(MAX_LOG2)) ? 3'(MAX_LOG2) : size_ff;
   end

   function automatic logic [AW-1:0] rev(input logic [AW-1:0] x, input logic [2:0] m);
      logic [AW-1:0] r;
      r = '0;
      for (int b = 0; b < AW; b++)
         if (3'(b) < m) r[3'(m - 3'(b) - 3'd1)] = x[b];
      return r;
   endfunction

   logic [AW-1:0] rev_i, rev_ip;
   always_comb begin
      rev_i = cnt_ff[AW-1:0];
      rev_ip = rev(rev_i, m_ff);
   end

   fft_sequencer u_seq (
      .clock(clock), .reset(reset), .go(go), .m(m_ff), .cmd(cmd), .done(seq_done)
   );

   // inverse: butterfly sees imag as its real side, both ways
   always_comb begin
      bf_ar = inv_blk_ff ? qa_im_ff : qa_re_ff;
      bf_ai = inv_blk_ff ? qa_re_ff : qa_im_ff;
      bf_br = inv_blk_ff ? qb_im_ff : qb_re_ff;
      bf_bi = inv_blk_ff ? qb_re_ff : qb_im_ff;
   end

   fft_butterfly u_bfly (
      .clock(clock), .cmd(cmd_ff),
      .ar(bf_ar), .ai(bf_ai), .br(bf_br), .bi(bf_bi),
      .cmd_out(cmd_wb), .yr0(yr0), .yi0(yi0), .yr1(yr1), .yi1(yi1)
   );

   // read addresses
   always_comb begin
      rd_a = cmd.addr_a;
      rd_b = cmd.addr_b;
      if (state_ff == S_REV) begin
         rd_a = rev_i;
         rd_b = rev_ip;
      end else if (state_ff == S_OUT) begin
         rd_a = cnt_ff[AW-1:0];
      end
   end

   // write ports; words load unswapped, butterfly results swap back
   sample_type ld_re, ld_im;
   always_comb begin
      ld_re = req_sample_real;
      ld_im = req_sample_imag;
      we_a = 1'b0; we_b = 1'b0;
      wa = cmd_wb.addr_a; wb = cmd_wb.addr_b;
      wa_re = inv_blk_ff ? yi0 : yr0;
      wa_im = inv_blk_ff ? yr0 : yi0;
      wb_re = inv_blk_ff ? yi1 : yr1;
      wb_im = inv_blk_ff ? yr1 : yi1;
      if (state_ff == S_LOAD) begin
         we_a = start;
         wa = cnt_ff[AW-1:0];
         wa_re = ld_re; wa_im = ld_im;
      end else if (rev_v_ff) begin
         we_a = rev_i_ff < rev_ip_ff;
         we_b = we_a;
         wa = rev_i_ff; wb = rev_ip_ff;
         wa_re = qb_re_ff; wa_im = qb_im_ff;
         wb_re = qa_re_ff; wb_im = qa_im_ff;
      end else if (cmd_wb.valid) begin
         we_a = 1'b1; we_b = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_re[wa] <= wa_re;
         mem_im[wa] <= wa_im;
      end
      if (we_b) begin
         mem_re[wb] <= wb_re;
         mem_im[wb] <= wb_im;
      end
      qa_re_ff <= mem_re[rd_a];
      qa_im_ff <= mem_im[rd_a];
      qb_re_ff <= mem_re[rd_b];
      qb_im_ff <= mem_im[rd_b];
      cmd_ff <= cmd;
      rev_i_ff <= rev_i;
      rev_ip_ff <= rev_ip;
   end

   // control
   logic [AW:0] n_cur, n_blk;
   always_comb begin
      n_cur = (AW+1)'(1) << m_eff;
      n_blk = (AW+1)'(1) << m_ff;
      state_in = state_ff;
      cnt_in = cnt_ff;
      m_in = m_ff;
      inv_blk_in = inv_blk_ff;
      drain_in = drain_ff;
      go = 1'b0;
      case (state_ff)
         S_LOAD: begin
            if (start) begin
               if ((cnt_ff + 1'b1) >= n_cur) begin
                  cnt_in = '0;
                  m_in = m_eff;
                  inv_blk_in = inv_ff;
                  state_in = S_REV;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_REV: begin
            // the swap write lands the cycle after the read
            if ((cnt_ff + 1'b1) >= n_blk) begin
               cnt_in = '0;
               go = 1'b1;
               state_in = S_BFLY;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_BFLY: begin
            if (seq_done) begin
               drain_in = 2'd3;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (drain_ff == 2'd0) begin
               cnt_in = '0;
               state_in = S_OUT;
            end else begin
               drain_in = drain_ff - 2'd1;
            end
         end
         S_OUT: begin
            if ((cnt_ff + 1'b1) >= n_blk) begin
               cnt_in = '0;
               state_in = S_LOAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff <= '0;
         m_ff <= 3'(MAX_LOG2);
         inv_blk_ff <= 1'b0;
         drain_ff <= '0;
         size_ff <= 3'd6;
         inv_ff <= 1'b0;
         rev_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         out_k_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         m_ff <= m_in;
         inv_blk_ff <= inv_blk_in;
         drain_ff <= drain_in;
         rev_v_ff <= (state_ff == S_REV);
         out_v_ff <= (state_ff == S_OUT);
         out_k_ff <= cnt_ff;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SIZE_LOG2: size_ff <= csr_data;
               CSR_INVERSE:   inv_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // bitreverse: read a pair into the read registers, write it back swapped from
   // them. Pairs are disjoint, so no read-after-write hazard across them.
   // Butterflies: a write follows the memory read and product registers. Within
   // a stage every entry is touched once; the sequencer's idle cycles
   // between stages keep the next stage's reads behind the last writes.
   assign busy = (state_ff != S_LOAD);
   assign csr_ready = (state_ff == S_LOAD) && !out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_bin_real = qa_re_ff;
   assign rsp_bin_imag = qa_im_ff;
   assign rsp_bin_last = out_v_ff && ((out_k_ff + 1'b1) == n_blk);

`include "fixed_point_radix2_fft_assert.svh"
   `FFT_ASSERT_IMPL(a_no_csr_in_bins, clock, reset, !(rsp_valid && csr_ready), "csr open during bins")
   `FFT_ASSERT_NEXT(a_go_bfly, clock, reset, go, state_ff == S_BFLY, "go without butterfly state")
   `FFT_ASSERT_IMPL(a_wb_in_bfly, clock, reset, !(cmd_wb.valid && state_ff == S_LOAD), "write back while loading")
endmodule
